// File: rtl/rtbd_pkg.sv
// rtbd_pkg: shared constants and word types of the three-body derivative pipeline
`default_nettype none

package rtbd_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 24;
    localparam int CFG_BITS  = 24;
    localparam logic [CFG_BITS-1:0] MASS_RESET = CFG_BITS'(16777);

    localparam int N_TERMS    = 6;
    localparam int MAX_BITS   = (WORD_BITS - 1 > FRAC_BITS) ? WORD_BITS - 1 : FRAC_BITS;
    localparam int MAG_BITS   = MAX_BITS + 2;
    localparam int OFS_BITS   = MAG_BITS + 1;
    localparam int MU_BITS    = FRAC_BITS + 1;
    localparam int SQ_BITS    = 2 * MAG_BITS;
    localparam int SUM_BITS   = SQ_BITS + 2;
    localparam int ROOT_BITS  = SUM_BITS / 2;
    localparam int TRIAL_BITS = SUM_BITS + 2;
    localparam int DEN_BITS   = ROOT_BITS + SUM_BITS;
    localparam int PROD_BITS  = MU_BITS + MAG_BITS;
    localparam int NUM_BITS   = PROD_BITS + 2 * FRAC_BITS;
    localparam int QUO_BITS   = WORD_BITS + 3;
    localparam int CMP_BITS   = ((DEN_BITS + QUO_BITS > NUM_BITS) ?
                                 DEN_BITS + QUO_BITS : NUM_BITS) + 1;
    localparam int BASE_BITS  = WORD_BITS + 2;
    localparam int ACC_BITS   = WORD_BITS + 5;
    localparam int LATENCY    = ROOT_BITS + QUO_BITS + 8;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] pos_x;
        logic signed [WORD_BITS-1:0] pos_y;
        logic signed [WORD_BITS-1:0] pos_z;
        logic signed [WORD_BITS-1:0] vel_x;
        logic signed [WORD_BITS-1:0] vel_y;
        logic signed [WORD_BITS-1:0] vel_z;
    } t_in_word;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] rate_x;
        logic signed [WORD_BITS-1:0] rate_y;
        logic signed [WORD_BITS-1:0] rate_z;
        logic signed [WORD_BITS-1:0] accel_x;
        logic signed [WORD_BITS-1:0] accel_y;
        logic signed [WORD_BITS-1:0] accel_z;
        logic                        saturated;
    } t_out_word;

    typedef struct packed {
        logic signed [WORD_BITS-1:0]          rate_x;
        logic signed [WORD_BITS-1:0]          rate_y;
        logic signed [WORD_BITS-1:0]          rate_z;
        logic signed [BASE_BITS-1:0]          base_x;
        logic signed [BASE_BITS-1:0]          base_y;
        logic [N_TERMS-1:0]                   neg;
        logic [1:0]                           zero;
        logic [N_TERMS-1:0][PROD_BITS-1:0]    prod;
    } t_ctx;

endpackage

`default_nettype wire

// File: rtl/restricted_three_body_derivative.sv
// restricted_three_body_derivative: pipelined rotating-frame three-body derivative
//
// One state word is taken on every cycle at which start is high; busy never rises. Each word
// gives one result word on o_result, marked by o_strobe for one cycle, in order. The
// latency is set by the two bit-per-stage square-root chains (34 stages) and the six
// bit-per-stage dividers (one check stage and 35 quotient stages); results cannot be held
// off. The mass ratio must be written through the cfg channel, which is always ready, only
// while no word is in flight; the block itself does not enforce this.
`default_nettype none

module restricted_three_body_derivative (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  rtbd_pkg::t_in_word           i_item,
    output logic                         o_strobe,
    output rtbd_pkg::t_out_word          o_result,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [rtbd_pkg::CFG_BITS-1:0] i_cfg_data
);

    localparam int NT  = rtbd_pkg::N_TERMS;
    localparam int RB  = rtbd_pkg::ROOT_BITS;
    localparam int QB  = rtbd_pkg::QUO_BITS;
    localparam int SB  = rtbd_pkg::SUM_BITS;
    localparam int MB  = rtbd_pkg::MAG_BITS;
    localparam int OB  = rtbd_pkg::OFS_BITS;
    localparam int UB  = rtbd_pkg::MU_BITS;
    localparam int AB  = rtbd_pkg::ACC_BITS;
    localparam int WB  = rtbd_pkg::WORD_BITS;
    localparam int NB  = rtbd_pkg::NUM_BITS;
    localparam int CB  = rtbd_pkg::CMP_BITS;
    localparam int DB  = rtbd_pkg::DEN_BITS;
    localparam int TB  = rtbd_pkg::TRIAL_BITS;
    localparam int BB  = rtbd_pkg::BASE_BITS;

    localparam logic [UB-1:0] ONE = UB'(1) << rtbd_pkg::FRAC_BITS;
    localparam logic [QB-1:0] LIM = QB'(1) << (WB + 2);
    localparam logic signed [AB-1:0] ACC_HI = (AB'(1) <<< (WB - 1)) - AB'(1);
    localparam logic signed [AB-1:0] ACC_LO = -ACC_HI - AB'(1);

    function automatic logic [MB-1:0] f_mag(input logic signed [OB-1:0] v);
        f_mag = MB'(v[OB-1] ? -v : v);
    endfunction

    // configuration
    logic [rtbd_pkg::CFG_BITS-1:0] r_mass;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass <= rtbd_pkg::MASS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mass <= i_cfg_data;
        end
    end

    // stage a: offsets and magnitudes
    logic [UB-1:0]          mu_c, wm_c;
    logic signed [OB-1:0]   d1_c, d2_c;
    rtbd_pkg::t_ctx         ctx_a_c;
    logic [MB-1:0]          mag_a_c [NT];

    logic                   r_a_vld;
    rtbd_pkg::t_ctx         r_a_ctx;
    logic [MB-1:0]          r_a_mag [NT];
    logic [UB-1:0]          r_a_mu, r_a_wm;

    always_comb begin
        mu_c = (UB'(r_mass) > ONE) ? ONE : UB'(r_mass);
        wm_c = ONE - mu_c;
        d1_c = OB'(i_item.pos_x) + OB'(signed'({1'b0, mu_c}));
        d2_c = d1_c - OB'(signed'({1'b0, ONE}));
        mag_a_c[0] = f_mag(d1_c);
        mag_a_c[1] = f_mag(OB'(i_item.pos_y));
        mag_a_c[2] = f_mag(OB'(i_item.pos_z));
        mag_a_c[3] = f_mag(d2_c);
        mag_a_c[4] = mag_a_c[1];
        mag_a_c[5] = mag_a_c[2];
        ctx_a_c        = '0;
        ctx_a_c.rate_x = i_item.vel_x;
        ctx_a_c.rate_y = i_item.vel_y;
        ctx_a_c.rate_z = i_item.vel_z;
        ctx_a_c.base_x = BB'(i_item.pos_x) + (BB'(i_item.vel_y) <<< 1);
        ctx_a_c.base_y = BB'(i_item.pos_y) - (BB'(i_item.vel_x) <<< 1);
        ctx_a_c.neg    = {i_item.pos_z[WB-1], i_item.pos_y[WB-1], d2_c[OB-1],
                          i_item.pos_z[WB-1], i_item.pos_y[WB-1], d1_c[OB-1]};
    end

    always_ff @(posedge i_clk) begin
        r_a_ctx <= ctx_a_c;
        r_a_mag <= mag_a_c;
        r_a_mu  <= mu_c;
        r_a_wm  <= wm_c;
    end

    // stage b: squares and pull numerators
    rtbd_pkg::t_ctx         ctx_b_c;
    logic                   r_b_vld;
    rtbd_pkg::t_ctx         r_b_ctx;
    logic [rtbd_pkg::SQ_BITS-1:0] r_b_sq [4];

    always_comb begin
        ctx_b_c = r_a_ctx;
        for (int j = 0; j < NT; j++) begin
            ctx_b_c.prod[j] = rtbd_pkg::PROD_BITS'(j < 3 ? r_a_wm : r_a_mu) *
                              rtbd_pkg::PROD_BITS'(r_a_mag[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_ctx   <= ctx_b_c;
        r_b_sq[0] <= rtbd_pkg::SQ_BITS'(r_a_mag[0]) * rtbd_pkg::SQ_BITS'(r_a_mag[0]);
        r_b_sq[1] <= rtbd_pkg::SQ_BITS'(r_a_mag[3]) * rtbd_pkg::SQ_BITS'(r_a_mag[3]);
        r_b_sq[2] <= rtbd_pkg::SQ_BITS'(r_a_mag[1]) * rtbd_pkg::SQ_BITS'(r_a_mag[1]);
        r_b_sq[3] <= rtbd_pkg::SQ_BITS'(r_a_mag[2]) * rtbd_pkg::SQ_BITS'(r_a_mag[2]);
    end

    // stage c: squared distances
    logic [SB-1:0]          s_c [2];
    rtbd_pkg::t_ctx         ctx_c_c;
    logic                   r_c_vld;
    rtbd_pkg::t_ctx         r_c_ctx;
    logic [SB-1:0]          r_c_s [2];

    always_comb begin
        for (int p = 0; p < 2; p++) begin
            s_c[p] = SB'(r_b_sq[p]) + SB'(r_b_sq[2]) + SB'(r_b_sq[3]);
        end
        ctx_c_c      = r_b_ctx;
        ctx_c_c.zero = {s_c[1] == '0, s_c[0] == '0};
    end

    always_ff @(posedge i_clk) begin
        r_c_ctx <= ctx_c_c;
        r_c_s   <= s_c;
    end

    // square-root chain, one root bit a stage
    logic                   r_q_vld  [RB];
    rtbd_pkg::t_ctx         r_q_ctx  [RB];
    logic [SB-1:0]          r_q_s    [RB][2];
    logic [SB-1:0]          r_q_rem  [RB][2];
    logic [RB-1:0]          r_q_root [RB][2];

    for (genvar k = 0; k < RB; k++) begin : g_sqrt
        localparam int BIT = RB - 1 - k;
        logic                   vld_in;
        rtbd_pkg::t_ctx         ctx_in;
        logic [SB-1:0]          s_in    [2];
        logic [SB-1:0]          rem_in  [2];
        logic [RB-1:0]          root_in [2];
        logic [SB-1:0]          rem_nx  [2];
        logic [RB-1:0]          root_nx [2];

        if (k == 0) begin : g_first
            assign vld_in = r_c_vld;
            assign ctx_in = r_c_ctx;
            always_comb begin
                for (int p = 0; p < 2; p++) begin
                    s_in[p]    = r_c_s[p];
                    rem_in[p]  = r_c_s[p];
                    root_in[p] = '0;
                end
            end
        end else begin : g_next
            assign vld_in = r_q_vld[k-1];
            assign ctx_in = r_q_ctx[k-1];
            always_comb begin
                for (int p = 0; p < 2; p++) begin
                    s_in[p]    = r_q_s[k-1][p];
                    rem_in[p]  = r_q_rem[k-1][p];
                    root_in[p] = r_q_root[k-1][p];
                end
            end
        end

        always_comb begin
            logic [TB-1:0] trial;
            logic          ge;
            for (int p = 0; p < 2; p++) begin
                trial = (TB'(root_in[p]) << (BIT + 1)) | (TB'(1) << (2 * BIT));
                ge    = TB'(rem_in[p]) >= trial;
                rem_nx[p]  = ge ? SB'(TB'(rem_in[p]) - trial) : rem_in[p];
                root_nx[p] = root_in[p] | (ge ? (RB'(1) << BIT) : '0);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q_vld[k] <= 1'b0;
            end else begin
                r_q_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_q_ctx[k]  <= ctx_in;
            r_q_s[k]    <= s_in;
            r_q_rem[k]  <= rem_nx;
            r_q_root[k] <= root_nx;
        end
    end

    // stage d and e: r times s as two half products
    logic                   r_d_vld, r_e_vld;
    rtbd_pkg::t_ctx         r_d_ctx, r_e_ctx;
    logic [SB-1:0]          r_d_lo [2], r_d_hi [2];
    logic [DB-1:0]          r_e_den [2];

    always_ff @(posedge i_clk) begin
        r_d_ctx <= r_q_ctx[RB-1];
        for (int p = 0; p < 2; p++) begin
            r_d_lo[p] <= SB'(r_q_root[RB-1][p]) * SB'(r_q_s[RB-1][p][RB-1:0]);
            r_d_hi[p] <= SB'(r_q_root[RB-1][p]) * SB'(r_q_s[RB-1][p][SB-1:RB]);
        end
        r_e_ctx <= r_d_ctx;
        for (int p = 0; p < 2; p++) begin
            r_e_den[p] <= (DB'(r_d_hi[p]) << RB) + DB'(r_d_lo[p]);
        end
    end

    // stage v: overflow check ahead of the dividers
    logic                   r_v_vld;
    rtbd_pkg::t_ctx         r_v_ctx;
    logic [NB-1:0]          r_v_rem [NT];
    logic [NT-1:0]          r_v_ovf;
    logic [DB-1:0]          r_v_den [2];

    always_ff @(posedge i_clk) begin
        r_v_ctx <= r_e_ctx;
        r_v_den <= r_e_den;
        for (int j = 0; j < NT; j++) begin
            r_v_rem[j] <= NB'(r_e_ctx.prod[j]) << (2 * rtbd_pkg::FRAC_BITS);
            r_v_ovf[j] <= (CB'(NB'(r_e_ctx.prod[j]) << (2 * rtbd_pkg::FRAC_BITS))) >=
                          (CB'(r_e_den[j >= 3 ? 1 : 0]) << QB);
        end
    end

    // dividers, one quotient bit a stage
    logic                   r_dv_vld [QB];
    rtbd_pkg::t_ctx         r_dv_ctx [QB];
    logic [NB-1:0]          r_dv_rem [QB][NT];
    logic [QB-1:0]          r_dv_quo [QB][NT];
    logic [DB-1:0]          r_dv_den [QB][2];
    logic [NT-1:0]          r_dv_ovf [QB];

    for (genvar k = 0; k < QB; k++) begin : g_div
        localparam int BIT = QB - 1 - k;
        logic                   vld_in;
        rtbd_pkg::t_ctx         ctx_in;
        logic [NB-1:0]          rem_in [NT];
        logic [QB-1:0]          quo_in [NT];
        logic [DB-1:0]          den_in [2];
        logic [NT-1:0]          ovf_in;
        logic [NB-1:0]          rem_nx [NT];
        logic [QB-1:0]          quo_nx [NT];

        if (k == 0) begin : g_first
            assign vld_in = r_v_vld;
            assign ctx_in = r_v_ctx;
            assign ovf_in = r_v_ovf;
            always_comb begin
                den_in = r_v_den;
                for (int j = 0; j < NT; j++) begin
                    rem_in[j] = r_v_rem[j];
                    quo_in[j] = '0;
                end
            end
        end else begin : g_next
            assign vld_in = r_dv_vld[k-1];
            assign ctx_in = r_dv_ctx[k-1];
            assign ovf_in = r_dv_ovf[k-1];
            always_comb begin
                den_in = r_dv_den[k-1];
                for (int j = 0; j < NT; j++) begin
                    rem_in[j] = r_dv_rem[k-1][j];
                    quo_in[j] = r_dv_quo[k-1][j];
                end
            end
        end

        always_comb begin
            logic [CB-1:0] sub;
            logic          ge;
            for (int j = 0; j < NT; j++) begin
                sub       = CB'(den_in[j >= 3 ? 1 : 0]) << BIT;
                ge        = CB'(rem_in[j]) >= sub;
                rem_nx[j] = ge ? NB'(CB'(rem_in[j]) - sub) : rem_in[j];
                quo_nx[j] = quo_in[j] | (ge ? (QB'(1) << BIT) : '0);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k] <= 1'b0;
            end else begin
                r_dv_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv_ctx[k] <= ctx_in;
            r_dv_rem[k] <= rem_nx;
            r_dv_quo[k] <= quo_nx;
            r_dv_den[k] <= den_in;
            r_dv_ovf[k] <= ovf_in;
        end
    end

    // stage f: clamp, sign and sum the pulls
    rtbd_pkg::t_ctx         ctx_f;
    logic signed [AB-1:0]   term_c [NT];
    logic signed [AB-1:0]   acc_c  [3];
    logic                   r_f_vld;
    rtbd_pkg::t_ctx         r_f_ctx;
    logic signed [AB-1:0]   r_f_acc [3];

    assign ctx_f = r_dv_ctx[QB-1];

    always_comb begin
        logic [QB-1:0]        tmag;
        logic signed [AB-1:0] tval;
        for (int j = 0; j < NT; j++) begin
            if (ctx_f.zero[j >= 3 ? 1 : 0]) begin
                tmag = '0;
            end else if (r_dv_ovf[QB-1][j] || r_dv_quo[QB-1][j] > LIM) begin
                tmag = LIM;
            end else begin
                tmag = r_dv_quo[QB-1][j];
            end
            tval      = signed'(AB'(tmag));
            term_c[j] = ctx_f.neg[j] ? -tval : tval;
        end
        acc_c[0] = AB'(ctx_f.base_x) - term_c[0] - term_c[3];
        acc_c[1] = AB'(ctx_f.base_y) - term_c[1] - term_c[4];
        acc_c[2] = -term_c[2] - term_c[5];
    end

    always_ff @(posedge i_clk) begin
        r_f_ctx <= ctx_f;
        r_f_acc <= acc_c;
    end

    // stage g: saturate to the word range
    rtbd_pkg::t_out_word    out_c;
    rtbd_pkg::t_out_word    r_out;
    logic                   r_strobe;

    always_comb begin
        logic [2:0] clip;
        logic signed [WB-1:0] sat [3];
        for (int i = 0; i < 3; i++) begin
            clip[i] = (r_f_acc[i] > ACC_HI) || (r_f_acc[i] < ACC_LO);
            if (r_f_acc[i] > ACC_HI) begin
                sat[i] = WB'(ACC_HI);
            end else if (r_f_acc[i] < ACC_LO) begin
                sat[i] = WB'(ACC_LO);
            end else begin
                sat[i] = WB'(r_f_acc[i]);
            end
        end
        out_c.rate_x    = r_f_ctx.rate_x;
        out_c.rate_y    = r_f_ctx.rate_y;
        out_c.rate_z    = r_f_ctx.rate_z;
        out_c.accel_x   = sat[0];
        out_c.accel_y   = sat[1];
        out_c.accel_z   = sat[2];
        out_c.saturated = (|clip) || (|r_f_ctx.zero);
    end

    always_ff @(posedge i_clk) begin
        r_out <= out_c;
    end

    // valid bits of the fixed stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_b_vld  <= 1'b0;
            r_c_vld  <= 1'b0;
            r_d_vld  <= 1'b0;
            r_e_vld  <= 1'b0;
            r_v_vld  <= 1'b0;
            r_f_vld  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_a_vld  <= start && !busy;
            r_b_vld  <= r_a_vld;
            r_c_vld  <= r_b_vld;
            r_d_vld  <= r_q_vld[RB-1];
            r_e_vld  <= r_d_vld;
            r_v_vld  <= r_e_vld;
            r_f_vld  <= r_dv_vld[QB-1];
            r_strobe <= r_f_vld;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

`default_nettype wire

// File: rtl/rtbd_checker.sv
// rtbd_checker: port-level checks of the derivative pipeline and its bind
`default_nettype none

module rtbd_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 start,
    input wire                 busy,
    input rtbd_pkg::t_in_word  i_item,
    input wire                 o_strobe,
    input rtbd_pkg::t_out_word o_result
);

    localparam int LAT = rtbd_pkg::LATENCY;

    // every accepted word comes out after the fixed latency
    a_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_strobe)
        else $error("accepted word gave no result");

    // no result without a word taken the latency before
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result without an accepted word");

    // position rates are the velocities of the matching word
    a_rates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.rate_x == $past(i_item.vel_x, LAT)) &&
                     (o_result.rate_y == $past(i_item.vel_y, LAT)) &&
                     (o_result.rate_z == $past(i_item.vel_z, LAT)))
        else $error("rates do not match the word");

endmodule

bind restricted_three_body_derivative rtbd_checker u_rtbd_checker (.*);

`default_nettype wire
